// ===== hw/rtl/crc16fa_pkg.sv =====
package crc16fa_pkg;

   localparam int unsigned CRC_WIDTH  = 16;
   localparam int unsigned BYTE_WIDTH = 8;
   localparam int unsigned ADDR_WIDTH = 3;
   localparam int unsigned DATA_WIDTH = 32;

   localparam logic [CRC_WIDTH-1:0] CRC_START_RESET = 16'hFFFF;
   localparam logic [CRC_WIDTH-1:0] CRC_POLY_RESET  = 16'hA001;

   localparam logic CSR_IDX_START = 1'b0;
   localparam logic CSR_IDX_POLY  = 1'b1;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] data_byte;
      logic                  frame_end;
   } req_type;

   typedef struct packed {
      logic [BYTE_WIDTH-1:0] out_byte;
      logic                  out_is_crc;
      logic                  out_last;
   } rsp_type;

   // lsb-first crc update over one byte
   function automatic logic [CRC_WIDTH-1:0] crc_fold_byte(
      input logic [CRC_WIDTH-1:0]  crc,
      input logic [BYTE_WIDTH-1:0] data,
      input logic [CRC_WIDTH-1:0]  poly
   );
      logic [CRC_WIDTH-1:0] acc;
      acc = crc ^ {{(CRC_WIDTH-BYTE_WIDTH){1'b0}}, data};
      for (int i = 0; i < BYTE_WIDTH; i++) begin
         if (acc[0]) begin
            acc = (acc >> 1) ^ poly;
         end else begin
            acc = acc >> 1;
         end
      end
      return acc;
   endfunction

endpackage

// ===== hw/rtl/crc16_frame_appender.sv =====
// crc16_frame_appender
//
// Byte stream in on req_ (valid/ready), bytes out on rsp_ (valid/ready).
// Every input byte is passed through unchanged. A reflected CRC-16 runs over
// the frame's bytes; after the byte marked frame_end, the CRC low byte and then
// the CRC high byte follow, flagged out_is_crc, the high byte also out_last.
// The next frame starts again from crc_start.
// Registers on the APB-style port: crc_start at 0x0, crc_polynomial at 0x4.
// An input byte passes through the input register and then the output
// register; the byte-wide CRC update sits between them. Throughput: one
// byte per cycle while the receiver does not stall; a frame end holds the
// input register while the CRC low and high bytes go out.
// Reset clears both pipeline stages and the open-frame flag, and loads
// crc_start = 0xFFFF and crc_polynomial = 0xA001.
// When the receiver stalls, the output register holds its byte and the input
// register fills; req_ready then drops until the output moves again.
module crc16_frame_appender (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  crc16fa_pkg::req_type                    req_payload,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output crc16fa_pkg::rsp_type                    rsp_payload,
   input  logic                                    psel,
   input  logic                                    penable,
   input  logic                                    pwrite,
   input  logic [crc16fa_pkg::ADDR_WIDTH-1:0]      paddr,
   input  logic [crc16fa_pkg::DATA_WIDTH-1:0]      pwdata,
   output logic [crc16fa_pkg::DATA_WIDTH-1:0]      prdata,
   output logic                                    pready
);
   import crc16fa_pkg::*;

   typedef enum logic [1:0] {
      PH_DATA,
      PH_CRC_LO,
      PH_CRC_HI
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic                   in_valid_ff, in_valid_in;
   req_type                in_item_ff, in_item_in;
   logic                   out_valid_ff, out_valid_in;
   rsp_type                out_item_ff, out_item_in;
   logic [CRC_WIDTH-1:0]   running_crc_ff, running_crc_in;
   logic [CRC_WIDTH-1:0]   crc_hold_ff, crc_hold_in;
   logic                   frame_open_ff, frame_open_in;
   logic [CRC_WIDTH-1:0]   crc_start_ff, crc_start_in;
   logic [CRC_WIDTH-1:0]   crc_poly_ff, crc_poly_in;

   logic                   out_load;
   logic                   in_done;
   logic                   csr_write;
   logic [CRC_WIDTH-1:0]   crc_next;

   assign out_load  = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign in_done   = (phase_ff == PH_CRC_HI) || ((phase_ff == PH_DATA) && !in_item_ff.frame_end);
   assign req_ready = !in_valid_ff || (out_load && in_done);
   assign crc_next  = crc_fold_byte(frame_open_ff ? running_crc_ff : crc_start_ff,
                                    in_item_ff.data_byte, crc_poly_ff);

   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_comb begin
      prdata = '0;
      case (paddr[2])
         CSR_IDX_START: prdata[CRC_WIDTH-1:0] = crc_start_ff;
         CSR_IDX_POLY:  prdata[CRC_WIDTH-1:0] = crc_poly_ff;
         default:       prdata = '0;
      endcase
   end

   always_comb begin
      phase_in       = phase_ff;
      in_valid_in    = in_valid_ff;
      in_item_in     = in_item_ff;
      out_valid_in   = out_valid_ff;
      out_item_in    = out_item_ff;
      running_crc_in = running_crc_ff;
      crc_hold_in    = crc_hold_ff;
      frame_open_in  = frame_open_ff;
      crc_start_in   = crc_start_ff;
      crc_poly_in    = crc_poly_ff;

      if (csr_write) begin
         case (paddr[2])
            CSR_IDX_START: crc_start_in = pwdata[CRC_WIDTH-1:0];
            CSR_IDX_POLY:  crc_poly_in  = pwdata[CRC_WIDTH-1:0];
            default:       crc_start_in = crc_start_ff;
         endcase
      end

      if (rsp_valid && rsp_ready) begin
         out_valid_in = 1'b0;
      end

      if (out_load) begin
         out_valid_in = 1'b1;
         case (phase_ff)
            PH_DATA: begin
               out_item_in = '{out_byte: in_item_ff.data_byte, out_is_crc: 1'b0,
                               out_last: 1'b0};
               if (in_item_ff.frame_end) begin
                  crc_hold_in   = crc_next;
                  frame_open_in = 1'b0;
                  phase_in      = PH_CRC_LO;
               end else begin
                  running_crc_in = crc_next;
                  frame_open_in  = 1'b1;
               end
            end
            PH_CRC_LO: begin
               out_item_in = '{out_byte: crc_hold_ff[BYTE_WIDTH-1:0], out_is_crc: 1'b1,
                               out_last: 1'b0};
               phase_in    = PH_CRC_HI;
            end
            PH_CRC_HI: begin
               out_item_in = '{out_byte: crc_hold_ff[CRC_WIDTH-1:BYTE_WIDTH],
                               out_is_crc: 1'b1, out_last: 1'b1};
               phase_in    = PH_DATA;
            end
            default: begin
               phase_in = PH_DATA;
            end
         endcase
         if (in_done) begin
            in_valid_in = 1'b0;
         end
      end

      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_item_in  = req_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_DATA;
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         frame_open_ff <= 1'b0;
         crc_start_ff  <= CRC_START_RESET;
         crc_poly_ff   <= CRC_POLY_RESET;
      end else begin
         phase_ff      <= phase_in;
         in_valid_ff   <= in_valid_in;
         out_valid_ff  <= out_valid_in;
         frame_open_ff <= frame_open_in;
         crc_start_ff  <= crc_start_in;
         crc_poly_ff   <= crc_poly_in;
      end
      in_item_ff     <= in_item_in;
      out_item_ff    <= out_item_in;
      running_crc_ff <= running_crc_in;
      crc_hold_ff    <= crc_hold_in;
   end

   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_item_ff;

endmodule

// ===== hw/rtl/crc16fa_checker.sv =====
module crc16fa_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input crc16fa_pkg::rsp_type  rsp_payload,
   input logic                  pready
);
   import crc16fa_pkg::*;

   // stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("result changed while stalled");

   // frame end marker only on a crc byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.out_last |-> rsp_payload.out_is_crc)
      else $error("out_last without out_is_crc");

   // crc low byte is followed at once by the crc high byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_payload.out_is_crc && !rsp_payload.out_last
      |=> rsp_valid && rsp_payload.out_is_crc && rsp_payload.out_last)
      else $error("crc high byte missing after low byte");

   // output empty right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   assert property (@(posedge clock) disable iff (reset) pready)
      else $error("pready low");

endmodule

bind crc16_frame_appender crc16fa_checker u_crc16fa_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_payload (rsp_payload),
   .pready      (pready)
);

// ===== tb/sv/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import crc16fa_pkg::*;

   localparam logic [ADDR_WIDTH-1:0] START_ADDR = {CSR_IDX_START, 2'b00};
   localparam logic [ADDR_WIDTH-1:0] POLY_ADDR  = {CSR_IDX_POLY, 2'b00};
   localparam int unsigned DRAIN_CYCLES = 8;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_payload;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [ADDR_WIDTH-1:0] paddr = '0;
   logic [DATA_WIDTH-1:0] pwdata = '0;
   logic [DATA_WIDTH-1:0] prdata;
   logic                  pready;

   logic [CRC_WIDTH-1:0]  crc_start_model = CRC_START_RESET;
   logic [CRC_WIDTH-1:0]  crc_poly_model  = CRC_POLY_RESET;
   logic [CRC_WIDTH-1:0]  frame_crc       = CRC_START_RESET;
   logic                  frame_open      = 1'b0;

   rsp_type               expected_bytes[$];
   rsp_type               next_byte;
   int unsigned           mismatch_count = 0;
   int unsigned           req_gap_max = 16;
   int unsigned           rsp_gap_max = 16;

   crc16_frame_appender dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #1 clock = ~clock;

   initial begin
      #1000000;
      $display("crc16_frame_appender verification failed");
      $finish;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatch_count++;
   endtask

   // reflected crc, lsb first
   function automatic logic [CRC_WIDTH-1:0] fold_crc_byte(
      input logic [CRC_WIDTH-1:0]  crc,
      input logic [BYTE_WIDTH-1:0] data,
      input logic [CRC_WIDTH-1:0]  poly
   );
      logic [CRC_WIDTH-1:0] acc;
      acc = crc ^ {8'h00, data};
      for (int i = 0; i < BYTE_WIDTH; i++) begin
         acc = acc[0] ? ((acc >> 1) ^ poly) : (acc >> 1);
      end
      return acc;
   endfunction

   task automatic predict_frame_bytes(input logic [7:0] data, input logic last);
      logic [CRC_WIDTH-1:0] crc;
      crc = frame_open ? frame_crc : crc_start_model;
      crc = fold_crc_byte(crc, data, crc_poly_model);
      expected_bytes.push_back('{out_byte: data, out_is_crc: 1'b0, out_last: 1'b0});
      if (!last) begin
         frame_crc  = crc;
         frame_open = 1'b1;
      end else begin
         expected_bytes.push_back('{out_byte: crc[7:0], out_is_crc: 1'b1, out_last: 1'b0});
         expected_bytes.push_back('{out_byte: crc[15:8], out_is_crc: 1'b1, out_last: 1'b1});
         frame_crc  = crc_start_model;
         frame_open = 1'b0;
      end
   endtask

   task automatic send_byte(input logic [7:0] data, input logic last);
      int unsigned gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{data_byte: data, frame_end: last};
      @(posedge clock);
      while (!(req_valid && req_ready)) @(posedge clock);
      predict_frame_bytes(data, last);
   endtask

   task automatic wait_results_done();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_bytes.size() != 0);
   endtask

   task automatic drain();
      wait_results_done();
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic idx, input logic [CRC_WIDTH-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= (idx == CSR_IDX_POLY) ? POLY_ADDR : START_ADDR;
      pwdata  <= {16'h0000, value};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      if (idx == CSR_IDX_POLY) crc_poly_model = value;
      else crc_start_model = value;
   endtask

   task automatic csr_check(input logic idx);
      logic [DATA_WIDTH-1:0] want;
      want = {16'h0000, (idx == CSR_IDX_POLY) ? crc_poly_model : crc_start_model};
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= (idx == CSR_IDX_POLY) ? POLY_ADDR : START_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== want)
         report_mismatch($sformatf("register %0d read %08h, want %08h", idx, prdata, want));
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // receiver with random stalls per transaction
   initial begin
      int unsigned gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         gap = $urandom_range(0, rsp_gap_max);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_valid && rsp_ready)) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            report_mismatch($sformatf("unexpected transaction, byte %02h", rsp_payload.out_byte));
         end else begin
            next_byte = expected_bytes.pop_front();
            if (rsp_payload.out_byte !== next_byte.out_byte)
               report_mismatch($sformatf("out_byte %02h, want %02h",
                                         rsp_payload.out_byte, next_byte.out_byte));
            if (rsp_payload.out_is_crc !== next_byte.out_is_crc)
               report_mismatch($sformatf("out_is_crc %b, want %b",
                                         rsp_payload.out_is_crc, next_byte.out_is_crc));
            if (rsp_payload.out_last !== next_byte.out_last)
               report_mismatch($sformatf("out_last %b, want %b",
                                         rsp_payload.out_last, next_byte.out_last));
         end
      end
   end

   task automatic test_reset_defaults();
      csr_check(CSR_IDX_START);
      csr_check(CSR_IDX_POLY);
      send_byte(8'h01, 1'b0);
      send_byte(8'h03, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h0A, 1'b1);
      drain();
   endtask

   task automatic test_byte_extremes();
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h01, 1'b1);
      drain();
   endtask

   task automatic test_register_settings();
      csr_write(CSR_IDX_START, 16'h0000);
      csr_check(CSR_IDX_START);
      send_byte(8'h5A, 1'b0);
      send_byte(8'hA5, 1'b1);
      drain();
      csr_write(CSR_IDX_START, 16'hFFFF);
      csr_write(CSR_IDX_POLY, 16'h0000);
      csr_check(CSR_IDX_POLY);
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b1);
      drain();
      csr_write(CSR_IDX_START, 16'h0000);
      csr_write(CSR_IDX_POLY, 16'hFFFF);
      send_byte(8'hC3, 1'b1);
      drain();
   endtask

   task automatic test_start_change_mid_frame();
      csr_write(CSR_IDX_POLY, CRC_POLY_RESET);
      csr_write(CSR_IDX_START, 16'hFFFF);
      send_byte(8'h12, 1'b0);
      send_byte(8'h34, 1'b0);
      drain();
      csr_write(CSR_IDX_START, 16'h1D0F);
      send_byte(8'h56, 1'b0);
      send_byte(8'h78, 1'b1);
      send_byte(8'h9A, 1'b1);
      drain();
   endtask

   task automatic test_poly_change_mid_frame();
      send_byte(8'hDE, 1'b0);
      send_byte(8'hAD, 1'b0);
      drain();
      csr_write(CSR_IDX_POLY, 16'h8408);
      send_byte(8'hBE, 1'b0);
      send_byte(8'hEF, 1'b1);
      drain();
   endtask

   task automatic test_random_frames(input int unsigned n_items);
      int unsigned sent;
      int unsigned len;
      int unsigned pick;
      bit          paused;
      sent   = 0;
      paused = 1'b0;
      while (sent < n_items) begin
         if ($urandom_range(0, 3) == 0) begin
            req_gap_max = 0;
            rsp_gap_max = 0;
         end else begin
            req_gap_max = 16;
            rsp_gap_max = 16;
         end
         pick = $urandom_range(0, 9);
         if (pick < 7) len = $urandom_range(1, 8);
         else if (pick < 9) len = $urandom_range(9, 40);
         else len = 1;
         for (int i = 0; i < len; i++) begin
            send_byte(8'($urandom_range(0, 255)), (i == len - 1));
            sent++;
            if (!paused && sent >= n_items / 2) begin
               wait_results_done();
               paused = 1'b1;
            end
         end
         if ($urandom_range(0, 5) == 0) begin
            drain();
            pick = $urandom_range(0, 2);
            csr_write(CSR_IDX_START, (pick == 0) ? 16'h0000 :
                                     (pick == 1) ? 16'hFFFF : 16'($urandom));
            pick = $urandom_range(0, 3);
            csr_write(CSR_IDX_POLY, (pick == 0) ? 16'h0000 :
                                    (pick == 1) ? 16'hFFFF :
                                    (pick == 2) ? CRC_POLY_RESET : 16'($urandom));
         end
      end
      req_gap_max = 16;
      rsp_gap_max = 16;
      drain();
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_byte_extremes();
      test_register_settings();
      test_start_change_mid_frame();
      test_poly_change_mid_frame();
      test_random_frames(225);
      drain();
      if (mismatch_count == 0) begin
         $display("crc16_frame_appender verification clean");
      end else begin
         $display("crc16_frame_appender verification failed");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/crc16fa_pkg.sv
hw/rtl/crc16_frame_appender.sv
hw/rtl/crc16fa_checker.sv
tb/sv/tb_top.sv
